/* rtl/sub_crossover_duck_blend_assert.svh */
// Assertion macros used by the checker file of the blender.
`ifndef SUB_CROSSOVER_DUCK_BLEND_ASSERT_SVH
`define SUB_CROSSOVER_DUCK_BLEND_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define SCDB_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define SCDB_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/scdb_pkg.sv */
// Types and fixed constants of the sub-band / phantom blender.
package scdb_pkg;

    // coefficient fraction bits and unity in Q1.16
    localparam int          C_BITS     = 16;
    localparam logic [16:0] ONE_Q      = 17'h10000;
    // signed width of the short multiplier operand (coefficients, gains)
    localparam int          MB         = 18;
    localparam int          GAIN_FRAC  = 12;
    localparam int          WIDTH_FRAC = 14;
    // width stage is bypassed when |w - unity| * 100 <= unity
    localparam logic [15:0] WIDTH_UNITY   = 16'd16384;
    localparam logic [6:0]  WIDTH_TOL_MUL = 7'd100;

    // configuration port
    localparam int CFG_W = 17;

    typedef enum logic [2:0] {
        REG_LOWPASS_COEFF = 3'd0,
        REG_ATTACK_COEFF  = 3'd1,
        REG_RELEASE_COEFF = 3'd2,
        REG_DUCK_DEPTH    = 3'd3,
        REG_GHOST_AMOUNT  = 3'd4,
        REG_REPLACE_MODE  = 3'd5,
        REG_OUTPUT_GAIN   = 3'd6,
        REG_STEREO_WIDTH  = 3'd7
    } reg_idx_t;

    // register reset values
    localparam logic [15:0] RST_LOWPASS_COEFF = 16'd64853;
    localparam logic [15:0] RST_OUTPUT_GAIN   = 16'd4096;
    localparam logic [15:0] RST_STEREO_WIDTH  = 16'd16384;

    // word kinds carried in tuser bit 0
    localparam logic CMD_SIDECHAIN = 1'b0;
    localparam logic CMD_MIX       = 1'b1;

    // sequencer
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SC_LVL,
        ST_SC_DEP,
        ST_SC_ENV,
        ST_LP,
        ST_REP,
        ST_PHE,
        ST_PHG,
        ST_GAIN,
        ST_WID,
        ST_DONE
    } state_t;

    // passes of one shared multiply: high chunk, low chunk, write-back
    typedef enum logic [1:0] {
        PH_HI,
        PH_LO,
        PH_WB
    } phase_t;

endpackage

/* rtl/sub_crossover_duck_blend.sv */
// Top level: stereo sub-band / phantom blender with sidechain ducking envelope.
// One shared multiplier; each product runs a high chunk, a low chunk and a write-back.
// Sidechain word: a level step, then the depth and envelope products. Mix word: 4 or 5
// products per channel (replace mode adds one), one more for the width stage, then the output load.
// Mix word with ghost amount zero goes straight to the output load. Next word is taken once the sequencer is idle.
// Reset: registers to defaults, filter state to zero, envelope to unity; no clearing pass.
module sub_crossover_duck_blend #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    // configuration writes
    input  logic                                           cfg_we,
    input  scdb_pkg::reg_idx_t                             cfg_index,
    input  logic [scdb_pkg::CFG_W-1:0]                     cfg_data,
    // input words
    input  logic                                           s_tvalid,
    output logic                                           s_tready,
    // tdata: left_in, right_in, phantom_left, phantom_right
    input  logic [((4*SAMPLE_BITS+7)/8)*8-1:0]             s_tdata,
    // tuser: cmd, two_channels
    input  logic [1:0]                                     s_tuser,
    // result words
    output logic                                           m_tvalid,
    input  logic                                           m_tready,
    // tdata: left_out, right_out
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]             m_tdata
);
    import scdb_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int OUT_W  = ((2*SB+7)/8)*8;
    // wide multiplier operand, split into a low chunk of L bits and a high chunk of the rest
    localparam int WOP    = SB + 20;
    localparam int L      = (WOP + 1) / 2;
    localparam int ACC_W  = WOP + MB + 1;
    localparam int LPW    = SB + C_BITS;
    localparam int YW     = SB + 10;

    localparam logic signed [ACC_W-1:0] HALF16 = ACC_W'(1) <<< (C_BITS - 1);
    localparam logic signed [ACC_W-1:0] HALF_SC = ACC_W'(1) <<< (SB - 2);
    localparam logic signed [ACC_W-1:0] HALF_G = ACC_W'(1) <<< (GAIN_FRAC + C_BITS - 1);
    localparam logic signed [ACC_W-1:0] HALF_W = ACC_W'(1) <<< WIDTH_FRAC;
    localparam logic signed [YW-1:0]    SAT_HI = (YW'(1) <<< (SB - 1)) - YW'(1);
    localparam logic signed [YW-1:0]    SAT_LO = -SAT_HI - YW'(1);

    // configuration registers
    logic [15:0] lowpass_coeff_reg, attack_coeff_reg, release_coeff_reg;
    logic [16:0] duck_depth_reg, ghost_amount_reg;
    logic        replace_mode_reg;
    logic [15:0] output_gain_reg, stereo_width_reg;

    // control state
    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic   ch_reg, ch_next;
    logic   out_valid_reg, out_valid_next;
    logic [16:0]            env_reg, env_next;
    logic signed [LPW-1:0]  st_reg [2];
    logic signed [LPW-1:0]  st_next;
    logic                   st_we;

    // payload
    logic                   stereo_reg, stereo_next;
    logic signed [SB-1:0]   l_reg, r_reg, pl_reg, pr_reg;
    logic signed [SB-1:0]   l_next, r_next, pl_next, pr_next;
    logic [SB-1:0]          lvl_reg, lvl_next;
    logic [16:0]            tgt_reg, tgt_next;
    logic [15:0]            coef_reg, coef_next;
    logic signed [WOP-1:0]  m_reg, m_next, t_reg, t_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [YW-1:0]   yl_reg, yl_next, yr_reg, yr_next;
    logic signed [SB-1:0]   out_l_reg, out_l_next, out_r_reg, out_r_next;

    // datapath wires
    logic                    in_take;
    logic signed [SB-1:0]    x_cur, ph_cur;
    logic signed [LPW-1:0]   big_s, st_cur;
    logic signed [WOP-1:0]   mul_a;
    logic signed [MB-1:0]    mul_b;
    logic signed [L:0]       a_chunk;
    logic signed [L+MB:0]    prod;
    logic signed [ACC_W-1:0] acc_step;
    logic signed [ACC_W-1:0] acc_r16, acc_rsc, acc_rg;
    logic signed [ACC_W-1:0] lp_sum, rep_sum, env_sum;
    logic signed [ACC_W-1:0] wid_s, wid_l, wid_r;
    logic signed [19:0]      tgt_w;
    logic [SB-1:0]           abs_l, abs_r;
    logic signed [SB+17:0]   cmp_l, cmp_r;
    logic signed [17:0]      wd;
    logic [16:0]             wd_abs;
    logic [23:0]             wd_scaled;
    logic                    width_on;

    function automatic logic signed [SB-1:0] sat_y(input logic signed [YW-1:0] v);
        logic signed [YW-1:0] c;
        priority if (v > SAT_HI)
            c = SAT_HI;
        else if (v < SAT_LO)
            c = SAT_LO;
        else
            c = v;
        return SB'(c);
    endfunction

    assign s_tready = (state_reg == ST_IDLE);
    assign in_take  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_r_reg, out_l_reg});

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lowpass_coeff_reg <= RST_LOWPASS_COEFF;
            attack_coeff_reg  <= '0;
            release_coeff_reg <= '0;
            duck_depth_reg    <= '0;
            ghost_amount_reg  <= '0;
            replace_mode_reg  <= 1'b0;
            output_gain_reg   <= RST_OUTPUT_GAIN;
            stereo_width_reg  <= RST_STEREO_WIDTH;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LOWPASS_COEFF: lowpass_coeff_reg <= cfg_data[15:0];
                REG_ATTACK_COEFF:  attack_coeff_reg  <= cfg_data[15:0];
                REG_RELEASE_COEFF: release_coeff_reg <= cfg_data[15:0];
                REG_DUCK_DEPTH:    duck_depth_reg    <= cfg_data[16:0];
                REG_GHOST_AMOUNT:  ghost_amount_reg  <= cfg_data[16:0];
                REG_REPLACE_MODE:  replace_mode_reg  <= cfg_data[0];
                REG_OUTPUT_GAIN:   output_gain_reg   <= cfg_data[15:0];
                REG_STEREO_WIDTH:  stereo_width_reg  <= cfg_data[15:0];
            endcase
        end
    end

    // current channel operands
    assign x_cur  = ch_reg ? r_reg : l_reg;
    assign ph_cur = ch_reg ? pr_reg : pl_reg;
    assign big_s  = $signed({x_cur, {C_BITS{1'b0}}});
    assign st_cur = st_reg[ch_reg];

    // sidechain level: clamp to full scale is implicit, |x| never exceeds it
    assign abs_l = l_reg[SB-1] ? $unsigned(-l_reg) : $unsigned(l_reg);
    assign abs_r = r_reg[SB-1] ? $unsigned(-r_reg) : $unsigned(r_reg);

    // attack when level > 1 - envelope, both at level*2^16 scale
    assign cmp_l = $signed({2'b00, lvl_reg, {C_BITS{1'b0}}});
    assign cmp_r = (SB+18)'($signed(18'(ONE_Q)) - $signed({1'b0, env_reg})) <<< (SB - 1);

    // width stage in use
    assign wd        = $signed({2'b00, stereo_width_reg}) - $signed({2'b00, WIDTH_UNITY});
    assign wd_abs    = wd[17] ? 17'(-wd) : 17'(wd);
    assign wd_scaled = 24'(wd_abs) * 24'(WIDTH_TOL_MUL);
    assign width_on  = wd_scaled > 24'(WIDTH_UNITY);

    // operand selection for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SC_DEP:
            begin
                mul_a = WOP'($signed({1'b0, lvl_reg}));
                mul_b = $signed(MB'(duck_depth_reg));
            end
            ST_SC_ENV:
            begin
                mul_a = WOP'($signed({1'b0, env_reg}) - $signed({1'b0, tgt_reg}));
                mul_b = $signed(MB'(coef_reg));
            end
            ST_LP:
            begin
                mul_a = WOP'(st_cur) - WOP'(big_s);
                mul_b = $signed(MB'(lowpass_coeff_reg));
            end
            ST_REP:
            begin
                mul_a = WOP'(st_cur);
                mul_b = $signed(MB'(ONE_Q)) - $signed(MB'(ghost_amount_reg));
            end
            ST_PHE:
            begin
                mul_a = WOP'(ph_cur);
                mul_b = $signed(MB'(env_reg));
            end
            ST_PHG:
            begin
                mul_a = t_reg;
                mul_b = $signed(MB'(ghost_amount_reg));
            end
            ST_GAIN:
            begin
                mul_a = m_reg;
                mul_b = $signed(MB'(output_gain_reg));
            end
            ST_WID:
            begin
                mul_a = WOP'(yl_reg) - WOP'(yr_reg);
                mul_b = $signed(MB'(stereo_width_reg));
            end
            ST_IDLE, ST_SC_LVL, ST_DONE:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // shared multiply-accumulate: high chunk first, then low chunk
    assign a_chunk  = (phase_reg == PH_HI) ? (L+1)'($signed(mul_a[WOP-1:L]))
                                           : $signed({1'b0, mul_a[L-1:0]});
    assign prod     = a_chunk * mul_b;
    assign acc_step = (phase_reg == PH_HI) ? ACC_W'(prod)
                                           : (acc_reg <<< L) + ACC_W'(prod);

    // rounded write-back forms
    assign acc_r16 = (acc_reg + HALF16) >>> C_BITS;
    assign acc_rsc = (acc_reg + HALF_SC) >>> (SB - 1);
    assign acc_rg  = (acc_reg + HALF_G) >>> (GAIN_FRAC + C_BITS);
    assign lp_sum  = ACC_W'(big_s) + acc_r16;
    assign rep_sum = ACC_W'(big_s) - ACC_W'(st_cur) + acc_r16;
    assign env_sum = ACC_W'($signed({1'b0, tgt_reg})) + acc_r16;
    assign tgt_w   = $signed(20'(ONE_Q)) - 20'(acc_rsc);
    assign wid_s   = (ACC_W'(yl_reg) + ACC_W'(yr_reg)) <<< WIDTH_FRAC;
    assign wid_l   = (wid_s + acc_reg + HALF_W) >>> (WIDTH_FRAC + 1);
    assign wid_r   = (wid_s - acc_reg + HALF_W) >>> (WIDTH_FRAC + 1);

    // sequencer: next state and datapath loads
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        ch_next        = ch_reg;
        out_valid_next = out_valid_reg;
        env_next       = env_reg;
        st_next        = lp_sum[LPW-1:0];
        st_we          = 1'b0;
        stereo_next    = stereo_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        pl_next        = pl_reg;
        pr_next        = pr_reg;
        lvl_next       = lvl_reg;
        tgt_next       = tgt_reg;
        coef_next      = coef_reg;
        m_next         = m_reg;
        t_next         = t_reg;
        acc_next       = acc_reg;
        yl_next        = yl_reg;
        yr_next        = yr_reg;
        out_l_next     = out_l_reg;
        out_r_next     = out_r_reg;

        // result taken downstream
        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        // multiply passes
        if (phase_reg != PH_WB && state_reg != ST_IDLE && state_reg != ST_SC_LVL
            && state_reg != ST_DONE)
        begin
            acc_next   = acc_step;
            phase_next = (phase_reg == PH_HI) ? PH_LO : PH_WB;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    l_next      = $signed(s_tdata[SB-1:0]);
                    r_next      = $signed(s_tdata[2*SB-1:SB]);
                    pl_next     = $signed(s_tdata[3*SB-1:2*SB]);
                    pr_next     = $signed(s_tdata[4*SB-1:3*SB]);
                    stereo_next = s_tuser[1];
                    ch_next     = 1'b0;
                    phase_next  = PH_HI;
                    priority if (s_tuser[0] == CMD_SIDECHAIN)
                        state_next = ST_SC_LVL;
                    else if (ghost_amount_reg == '0)
                    begin
                        // bypass: dry word passes unchanged
                        yl_next    = YW'($signed(s_tdata[SB-1:0]));
                        yr_next    = YW'($signed(s_tdata[2*SB-1:SB]));
                        state_next = ST_DONE;
                    end
                    else
                        state_next = ST_LP;
                end
            end
            ST_SC_LVL:
            begin
                lvl_next = (stereo_reg && abs_r > abs_l) ? abs_r : abs_l;
                if (ghost_amount_reg == '0 || duck_depth_reg == '0)
                    state_next = ST_IDLE;
                else
                    state_next = ST_SC_DEP;
            end
            ST_SC_DEP:
            begin
                if (phase_reg == PH_WB)
                begin
                    tgt_next   = tgt_w[19] ? 17'd0 : tgt_w[16:0];
                    coef_next  = (cmp_l > cmp_r) ? attack_coeff_reg : release_coeff_reg;
                    phase_next = PH_HI;
                    state_next = ST_SC_ENV;
                end
            end
            ST_SC_ENV:
            begin
                if (phase_reg == PH_WB)
                begin
                    env_next   = env_sum[16:0];
                    phase_next = PH_HI;
                    state_next = ST_IDLE;
                end
            end
            ST_LP:
            begin
                if (phase_reg == PH_WB)
                begin
                    st_we      = 1'b1;
                    m_next     = WOP'(big_s);
                    phase_next = PH_HI;
                    state_next = replace_mode_reg ? ST_REP : ST_PHE;
                end
            end
            ST_REP:
            begin
                if (phase_reg == PH_WB)
                begin
                    m_next     = WOP'(rep_sum);
                    phase_next = PH_HI;
                    state_next = ST_PHE;
                end
            end
            ST_PHE:
            begin
                if (phase_reg == PH_WB)
                begin
                    // phantom times envelope, kept exact
                    t_next     = WOP'(acc_reg);
                    phase_next = PH_HI;
                    state_next = ST_PHG;
                end
            end
            ST_PHG:
            begin
                if (phase_reg == PH_WB)
                begin
                    m_next     = m_reg + WOP'(acc_r16);
                    phase_next = PH_HI;
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN:
            begin
                if (phase_reg == PH_WB)
                begin
                    if (ch_reg)
                        yr_next = YW'(acc_rg);
                    else
                        yl_next = YW'(acc_rg);
                    phase_next = PH_HI;
                    priority if (!ch_reg && stereo_reg)
                    begin
                        ch_next    = 1'b1;
                        state_next = ST_LP;
                    end
                    else if (stereo_reg && width_on)
                        state_next = ST_WID;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_WID:
            begin
                if (phase_reg == PH_WB)
                begin
                    yl_next    = YW'(wid_l);
                    yr_next    = YW'(wid_r);
                    phase_next = PH_HI;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // wait for a free output slot; mono echoes the right input
                if (!out_valid_reg || m_tready)
                begin
                    out_l_next     = sat_y(yl_reg);
                    out_r_next     = stereo_reg ? sat_y(yr_reg) : r_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_HI;
            ch_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            env_reg       <= ONE_Q;
            st_reg[0]     <= '0;
            st_reg[1]     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            ch_reg        <= ch_next;
            out_valid_reg <= out_valid_next;
            env_reg       <= env_next;
            if (st_we)
                st_reg[ch_reg] <= st_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        stereo_reg <= stereo_next;
        l_reg      <= l_next;
        r_reg      <= r_next;
        pl_reg     <= pl_next;
        pr_reg     <= pr_next;
        lvl_reg    <= lvl_next;
        tgt_reg    <= tgt_next;
        coef_reg   <= coef_next;
        m_reg      <= m_next;
        t_reg      <= t_next;
        acc_reg    <= acc_next;
        yl_reg     <= yl_next;
        yr_reg     <= yr_next;
        out_l_reg  <= out_l_next;
        out_r_reg  <= out_r_next;
    end

endmodule

/* rtl/scdb_checker.sv */
// Port-level checker for the blender, bound to the top level.
`include "sub_crossover_duck_blend_assert.svh"

module scdb_checker #(
    parameter int OUT_W = 48
) (
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    // stalled result word holds
    `SCDB_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")

    // one word at a time: busy right after a take
    `SCDB_ASSERT_NXT(a_busy_after_take, s_tvalid && s_tready, !s_tready, "input taken while a word is in work")

    // a new result only comes out of a busy sequencer
    `SCDB_ASSERT_IMP(a_result_from_work, $rose(m_tvalid), $past(!s_tready), "result word appeared with no word in work")

endmodule

bind sub_crossover_duck_blend scdb_checker #(.OUT_W(OUT_W)) u_scdb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
